// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/smdm_pkg.sv =====
package smdm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int SAMPLE_W   = 20;
   localparam int AGE_W      = $clog2(WINDOW_MAX);
   localparam int LEN_W      = 7;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W      = SAMPLE_W + AGE_W;
   localparam int COST_W     = 27;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LEN   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COST_CEILING = 1'b1;

   localparam logic [LEN_W-1:0]  WINDOW_LEN_RESET = LEN_W'(64);
   localparam logic [COST_W-1:0] CEILING_RESET    = COST_W'(100000);
   localparam logic [COST_W-1:0] COST_MAX         = {COST_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT,
      ST_LOAD,
      ST_SCAN,
      ST_MUL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic capture;
      logic remove;
      logic insert;
      logic load;
      logic scan;
      logic mul;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic fill_ok;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ===== src/smdm_ctrl.sv =====
`include "assert_macros.svh"

module smdm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  smdm_pkg::status_type status,
   output smdm_pkg::cmd_type    cmd
);
   import smdm_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_REMOVE;
         ST_REMOVE: state_in = ST_INSERT;
         ST_INSERT: state_in = status.fill_ok ? ST_LOAD : ST_IDLE;
         ST_LOAD:   state_in = ST_SCAN;
         ST_SCAN:   if (status.scan_last) state_in = ST_MUL;
         ST_MUL:    state_in = ST_FIN;
         ST_FIN:    if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_REMOVE: cmd.remove = 1'b1;
         ST_INSERT: cmd.insert = 1'b1;
         ST_LOAD:   cmd.load   = 1'b1;
         ST_SCAN:   cmd.scan   = 1'b1;
         ST_MUL:    cmd.mul    = 1'b1;
         ST_FIN:    cmd.fin    = 1'b1;
         default:   cmd        = '0;
      endcase
   end

   `AST_NEXT(a_scan_holds, clock, reset, (state_ff == ST_SCAN) && !status.scan_last, state_ff == ST_SCAN)

endmodule

// ===== src/smdm_datapath.sv =====
`include "assert_macros.svh"

module smdm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  smdm_pkg::cmd_type                 cmd,
   output smdm_pkg::status_type              status,
   input  logic [smdm_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                              req_start_new,
   input  logic [smdm_pkg::LEN_W-1:0]        len_eff,
   input  logic [smdm_pkg::COST_W-1:0]       cost_ceiling,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [smdm_pkg::COST_W-1:0]       rsp_window_cost,
   output logic [smdm_pkg::SAMPLE_W-1:0]     rsp_median_value,
   output logic [smdm_pkg::COST_W-1:0]       rsp_min_cost
);
   import smdm_pkg::*;

   // Captured word.
   logic [SAMPLE_W-1:0] sample_ff;
   logic                start_ff;

   // Sorted cells with ages; valid cells fill the low positions.
   logic [SAMPLE_W-1:0] cell_val_ff [WINDOW_MAX];
   logic [SAMPLE_W-1:0] cell_val_in [WINDOW_MAX];
   logic [AGE_W-1:0]    cell_age_ff [WINDOW_MAX];
   logic [AGE_W-1:0]    cell_age_in [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    fill_ff, fill_inc;

   // Scan line and accumulators.
   logic [SAMPLE_W-1:0] scan_val_ff [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] scan_q_ff;
   logic [AGE_W-1:0]    scan_cnt_ff;
   logic [CNT_W-1:0]    rank_ff;
   logic [SUM_W-1:0]    lower_ff, upper_ff, hm_ff, lm_ff;
   logic [SAMPLE_W-1:0] med_ff;
   logic [COST_W-1:0]   best_ff;
   logic [AGE_W-1:0]    half, up_cnt;
   logic [SUM_W+1:0]    cost_wide;
   logic [COST_W-1:0]   cost;
   logic [COST_W-1:0]   cost_out_ff, min_out_ff;
   logic [SAMPLE_W-1:0] med_out_ff;
   logic                rsp_valid_ff;
   logic                out_free;

   assign half   = len_eff[AGE_W:1];
   assign up_cnt = AGE_W'(len_eff - {1'b0, half} - LEN_W'(1));

   // Removal of the oldest cell (or all on a new start), then sorted insertion.
   always_comb begin
      logic          after;
      logic [WINDOW_MAX-1:0] gt;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         cell_val_in[i] = cell_val_ff[i];
         cell_age_in[i] = cell_age_ff[i];
      end
      valid_in = valid_ff;
      after    = 1'b0;
      gt       = '0;
      if (cmd.remove) begin
         if (start_ff) begin
            valid_in = '0;
         end else begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
               after = after | (valid_ff[i] && (cell_age_ff[i] == AGE_W'(WINDOW_MAX - 1)));
               if (after) begin
                  if (i < WINDOW_MAX - 1) begin
                     cell_val_in[i] = cell_val_ff[(i + 1) % WINDOW_MAX];
                     cell_age_in[i] = cell_age_ff[(i + 1) % WINDOW_MAX] + AGE_W'(1);
                     valid_in[i]    = valid_ff[(i + 1) % WINDOW_MAX];
                  end else begin
                     valid_in[i] = 1'b0;
                  end
               end else begin
                  cell_age_in[i] = cell_age_ff[i] + AGE_W'(1);
               end
            end
         end
      end else if (cmd.insert) begin
         for (int i = 0; i < WINDOW_MAX; i++) begin
            gt[i] = !valid_ff[i] || (cell_val_ff[i] > sample_ff);
         end
         for (int i = 0; i < WINDOW_MAX; i++) begin
            if (gt[i]) begin
               if (i > 0 && gt[(i + WINDOW_MAX - 1) % WINDOW_MAX]) begin
                  cell_val_in[i] = cell_val_ff[(i + WINDOW_MAX - 1) % WINDOW_MAX];
                  cell_age_in[i] = cell_age_ff[(i + WINDOW_MAX - 1) % WINDOW_MAX];
                  valid_in[i]    = valid_ff[(i + WINDOW_MAX - 1) % WINDOW_MAX];
               end else begin
                  cell_val_in[i] = sample_ff;
                  cell_age_in[i] = '0;
                  valid_in[i]    = 1'b1;
               end
            end
         end
      end
   end

   assign fill_inc       = (fill_ff < CNT_W'(WINDOW_MAX)) ? fill_ff + CNT_W'(1) : fill_ff;
   assign status.fill_ok = (len_eff <= fill_inc);
   assign status.scan_last = (scan_cnt_ff == AGE_W'(WINDOW_MAX - 1));

   // Cell storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int i = 0; i < WINDOW_MAX; i++) begin
         cell_val_ff[i] <= cell_val_in[i];
         cell_age_ff[i] <= cell_age_in[i];
      end
   end

   // Capture, fill count and running minimum.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         best_ff <= CEILING_RESET;
      end else begin
         if (cmd.remove && start_ff) begin
            fill_ff <= '0;
            best_ff <= cost_ceiling;
         end else if (cmd.insert) begin
            fill_ff <= fill_inc;
         end else if (cmd.fin && out_free && (cost < best_ff)) begin
            best_ff <= cost;
         end
      end
      if (cmd.capture) begin
         sample_ff <= req_sample;
         start_ff  <= req_start_new;
      end
   end

   // Ascending scan over the cells: rank the window members and sum each side.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < WINDOW_MAX; i++) begin
            scan_val_ff[i] <= cell_val_ff[i];
            scan_q_ff[i]   <= valid_ff[i] &&
                              ({{(LEN_W - AGE_W){1'b0}}, cell_age_ff[i]} < len_eff);
         end
         scan_cnt_ff <= '0;
         rank_ff     <= '0;
         lower_ff    <= '0;
         upper_ff    <= '0;
         med_ff      <= '0;
      end else if (cmd.scan) begin
         for (int i = 0; i < WINDOW_MAX - 1; i++) begin
            scan_val_ff[i] <= scan_val_ff[i + 1];
            scan_q_ff[i]   <= scan_q_ff[i + 1];
         end
         scan_q_ff[WINDOW_MAX-1] <= 1'b0;
         scan_cnt_ff <= scan_cnt_ff + AGE_W'(1);
         if (scan_q_ff[0]) begin
            rank_ff <= rank_ff + CNT_W'(1);
            if (rank_ff < {{(CNT_W - AGE_W){1'b0}}, half}) begin
               lower_ff <= lower_ff + {{AGE_W{1'b0}}, scan_val_ff[0]};
            end else if (rank_ff == {{(CNT_W - AGE_W){1'b0}}, half}) begin
               med_ff <= scan_val_ff[0];
            end else begin
               upper_ff <= upper_ff + {{AGE_W{1'b0}}, scan_val_ff[0]};
            end
         end
      end
      if (cmd.mul) begin
         hm_ff <= half * med_ff;
         lm_ff <= up_cnt * med_ff;
      end
   end

   // Final cost with saturation.
   assign cost_wide = {2'b00, hm_ff} - {2'b00, lower_ff} + {2'b00, upper_ff} - {2'b00, lm_ff};
   assign cost = (cost_wide > {{(SUM_W + 2 - COST_W){1'b0}}, COST_MAX}) ?
                 COST_MAX : cost_wide[COST_W-1:0];

   // Output register.
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.fin && out_free) begin
         cost_out_ff <= cost;
         med_out_ff  <= med_ff;
         min_out_ff  <= (cost < best_ff) ? cost : best_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_cost  = cost_out_ff;
   assign rsp_median_value = med_out_ff;
   assign rsp_min_cost     = min_out_ff;

   `AST_NEXT(a_fin_loads, clock, reset, cmd.fin && out_free, rsp_valid_ff)
   `AST_IMPL(a_min_le_cost, clock, reset, rsp_valid_ff, min_out_ff <= cost_out_ff)

endmodule

// ===== src/sliding_median_deviation_min_unit.sv =====
// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_sample, req_start_new
// rsp       out        rsp_valid, rsp_stall, rsp_window_cost, rsp_median_value, rsp_min_cost
// csr       in         csr_write_en, csr_index, csr_write_data
//
// A word that leaves the window short only removes and inserts; a full window then loads,
// runs the scan that walks all 64 sorted cells one per cycle, multiplies and finishes.
// Reset is synchronous, clears the cells and fill count and sets the running minimum to the reset ceiling.
// A waiting result in the output register does not block the next request word.
// While the output is stalled with a new result ready, the unit waits in its final step.
module sliding_median_deviation_min_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [smdm_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                               req_start_new,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [smdm_pkg::COST_W-1:0]        rsp_window_cost,
   output logic [smdm_pkg::SAMPLE_W-1:0]      rsp_median_value,
   output logic [smdm_pkg::COST_W-1:0]        rsp_min_cost,
   input  logic                               csr_write_en,
   input  logic [smdm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smdm_pkg::COST_W-1:0]        csr_write_data
);
   import smdm_pkg::*;

   logic [LEN_W-1:0]  window_len_ff;
   logic [COST_W-1:0] cost_ceiling_ff;
   logic [LEN_W-1:0]  len_eff;
   cmd_type           cmd;
   status_type        status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff   <= WINDOW_LEN_RESET;
         cost_ceiling_ff <= CEILING_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_WINDOW_LEN:   window_len_ff   <= csr_write_data[LEN_W-1:0];
            REG_COST_CEILING: cost_ceiling_ff <= csr_write_data;
            default:          cost_ceiling_ff <= cost_ceiling_ff;
         endcase
      end
   end

   // Window length clamped to the cell count; zero means one.
   always_comb begin
      if (window_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (window_len_ff > LEN_W'(WINDOW_MAX)) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end else begin
         len_eff = window_len_ff;
      end
   end

   smdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smdm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .req_start_new    (req_start_new),
      .len_eff          (len_eff),
      .cost_ceiling     (cost_ceiling_ff),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_window_cost  (rsp_window_cost),
      .rsp_median_value (rsp_median_value),
      .rsp_min_cost     (rsp_min_cost)
   );

endmodule
